### hdl/assert_macros.svh
// Assertion macros shared by the moving average filter RTL.
// Depends on nothing; expects clk and rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define MAF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define MAF_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### hdl/maf_pkg.sv
// Shared widths, constants and types of the moving average filter.
// No dependencies.
package maf_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = 40;
  localparam int CNT_W      = 9;
  localparam int AVG_W      = 48;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_WINDOW = 256;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int DIV_W      = SUM_W + FRAC_BITS;
  localparam int DCNT_W     = $clog2(DIV_W + 1);

  localparam logic [CNT_W-1:0] LEN_RESET = CNT_W'(16);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [PTR_W-1:0]           ptr_t;

  // One access to the sample ring: read the slot and write the new sample.
  typedef struct packed {
    logic    en;
    ptr_t    addr;
    sample_t wdata;
  } ring_req_t;

endpackage

### hdl/maf_ring.sv
// Sample ring of the moving average filter: single-port synchronous memory.
// Depends on maf_pkg. Read-before-write, one cycle read latency.
module maf_ring (
  input  logic               clk,
  input  maf_pkg::ring_req_t req,
  output maf_pkg::sample_t   rd_data
);
  import maf_pkg::*;

  sample_t mem [MAX_WINDOW];
  sample_t rd_data_r;

  // read returns the old contents of the slot being overwritten
  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_data_r     <= mem[req.addr];
      mem[req.addr] <= req.wdata;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/maf_div.sv
// Signed bit-serial divider: (sum << FRAC_BITS) / count, truncated toward zero.
// Depends on maf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module maf_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  maf_pkg::sum_t            sum,
  input  maf_pkg::cnt_t            count,
  output logic                     done,
  output logic [maf_pkg::AVG_W-1:0] quotient
);
  import maf_pkg::*;

  logic              busy_r, busy_nxt;
  logic              fix_r, fix_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r;
  logic              neg_r;
  cnt_t              div_r;
  cnt_t              rem_r;
  logic [DIV_W-1:0]  quo_r;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [SUM_W-1:0]  mag;

  assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = done_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r && cnt_r == DCNT_W'(1)) begin
      busy_nxt = 1'b0;
      fix_nxt  = 1'b1;
    end else if (fix_r) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
  end

  // one quotient bit per cycle, quotient shifts in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= {mag, FRAC_BITS'(0)};
      rem_r <= '0;
      div_r <= count;
      neg_r <= sum[SUM_W-1];
      cnt_r <= DCNT_W'(DIV_W);
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      cnt_r <= cnt_r - DCNT_W'(1);
    end else if (fix_r && neg_r) begin
      quo_r <= -quo_r;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[AVG_W-1:0];

  `MAF_NEVER(a_div_busy_done, busy_r && done_r, "divider busy and done together")
  `MAF_ASSERT(a_div_start_idle, start |-> !busy_r && !fix_r, "divider restarted while busy")
  `MAF_ASSERT(a_div_cnt_live, busy_r |-> cnt_r != '0, "divider iterating with no bits left")

endmodule

### hdl/moving_average_filter.sv
// Moving average filter top level: control sequencer, running sum and output register.
// Depends on maf_pkg, maf_ring, maf_div and assert_macros.svh.
//
// Each request carries one signed 32-bit sample. The sample enters a 256-entry
// ring memory, the oldest sample leaves it once the window is full, and a 40-bit
// running sum tracks the window. Each request yields one response: the average
// sum/count as signed fixed point with 16 fraction bits, truncated toward zero,
// and the number of samples in it. While the window fills the count grows by
// one per request and nothing leaves the sum. A request goes through the ring
// read, the sum update, the divider load, the bit-serial divider, which retires
// one of its 56 quotient bits per cycle, the sign fix and the output load, which
// waits while the output register is full; the next request is taken only after
// that load. A finished response waits in the output register, and the next
// request is taken while it waits. Writing cfg_wr_data sets the window length
// (zero is taken as one, anything above 256 as 256) and clears sum, count and
// ring pointer; write it only while no request is in flight. The ring needs no
// clearing after reset: only slots written since the last clear feed the sum.
`include "assert_macros.svh"
module moving_average_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [maf_pkg::CNT_W-1:0]   cfg_wr_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_sample,
  // response channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [47:0]          out_average,
  output logic [maf_pkg::CNT_W-1:0]   out_fill_count
);
  import maf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;  // wait for a request
  localparam logic [1:0] ST_READ  = 2'd1;  // oldest sample arrives from the ring
  localparam logic [1:0] ST_START = 2'd2;  // load the divider
  localparam logic [1:0] ST_DIV   = 2'd3;  // divide, then hand over the result

  logic [1:0] state_r, state_nxt;
  cnt_t       len_r, len_nxt;
  cnt_t       count_r, count_nxt;
  ptr_t       wptr_r, wptr_nxt;
  sum_t       sum_r, sum_nxt;
  logic       out_valid_r, out_valid_nxt;

  sample_t    sample_r;
  logic       full_r;
  logic signed [AVG_W-1:0] out_average_r;
  cnt_t       out_fill_count_r;

  logic       accept;
  logic       load_out;
  logic       div_start;
  logic       div_done;
  logic [AVG_W-1:0] div_quo;
  ring_req_t  ring_req;
  sample_t    ring_rd;
  sample_t    oldest;
  cnt_t       wptr_inc;
  cnt_t       cfg_len;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Hand the result over once the divider is done and the output slot is free.
  assign load_out  = (state_r == ST_DIV) && div_done && (!out_valid_r || out_ready);
  assign div_start = (state_r == ST_START);

  // Read the oldest slot and write the new sample in one access.
  assign ring_req.en    = accept;
  assign ring_req.addr  = wptr_r;
  assign ring_req.wdata = in_sample;

  // Nothing leaves the sum while the window is still filling.
  assign oldest   = full_r ? ring_rd : '0;
  assign wptr_inc = {1'b0, wptr_r} + CNT_W'(1);

  // Clamp the requested window length to between one and the ring depth.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_len = CNT_W'(1);
    end else if (cfg_wr_data > CNT_W'(MAX_WINDOW)) begin
      cfg_len = CNT_W'(MAX_WINDOW);
    end else begin
      cfg_len = cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    count_nxt     = count_r;
    wptr_nxt      = wptr_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // advance the pointer, wrap at the window length
          wptr_nxt  = (wptr_inc >= len_r) ? '0 : wptr_inc[PTR_W-1:0];
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        sum_nxt = sum_r - SUM_W'(oldest) + SUM_W'(sample_r);
        if (!full_r) begin
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a new window length restarts the window
    if (cfg_wr_en) begin
      len_nxt   = cfg_len;
      count_nxt = '0;
      wptr_nxt  = '0;
      sum_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LEN_RESET;
      count_r     <= '0;
      wptr_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      count_r     <= count_nxt;
      wptr_r      <= wptr_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      full_r   <= (count_r >= len_r);
    end
    if (load_out) begin
      out_average_r    <= div_quo;
      out_fill_count_r <= count_r;
    end
  end

  maf_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (ring_rd)
  );

  maf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sum      (sum_r),
    .count    (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid      = out_valid_r;
  assign out_average    = out_average_r;
  assign out_fill_count = out_fill_count_r;

  `MAF_ASSERT(a_count_in_window, count_r <= len_r, "fill count beyond window length")
  `MAF_ASSERT(a_wptr_in_window, {1'b0, wptr_r} < len_r, "ring pointer beyond window")
  `MAF_ASSERT(a_accept_reads, accept |=> state_r == ST_READ, "request did not start a ring read")

endmodule
